// ===== sv/sche_pkg.sv =====
// Shared types and constants for the sequenced channel header engine.
package sche_pkg;

    localparam int MAX_MESSAGE_BYTES = 1450;
    localparam int HEADER_RESERVE    = 8;
    localparam int CAP_INT           = MAX_MESSAGE_BYTES + HEADER_RESERVE;
    localparam int LEN_W             = $clog2(CAP_INT + 1);
    localparam int SEQ_W             = 31;
    localparam int WORD_W            = 32;
    localparam int TAG_W             = 16;
    localparam int HDR_INT           = 10;

    localparam logic [LEN_W-1:0] PKT_CAP   = LEN_W'(CAP_INT);
    localparam logic [LEN_W-1:0] HDR_BYTES = LEN_W'(HDR_INT);
    localparam logic [LEN_W-1:0] REL_ROOM  = LEN_W'(CAP_INT - HDR_INT);

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 192;

    typedef enum logic {
        OP_TX = 1'b0,
        OP_RX = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_SENT      = 3'd0,
        ST_FATAL     = 3'd1,
        ST_ACCEPTED  = 3'd2,
        ST_WRONG_SRC = 3'd3,
        ST_STALE     = 3'd4
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [10:0]      staged_bytes;
        logic             staged_overflow;
        logic [10:0]      unreliable_bytes;
        logic             source_matches;
        logic [WORD_W-1:0] rx_sequence_word;
        logic [WORD_W-1:0] rx_ack_word;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] tx_sequence_word;
        logic [WORD_W-1:0] tx_ack_word;
        logic              sent_reliable;
        logic              staged_taken;
        logic [10:0]       reliable_bytes;
        logic              unreliable_included;
        logic [10:0]       packet_bytes;
        logic [SEQ_W-1:0]  packets_dropped;
        logic [WORD_W-1:0] drop_events;
        logic [WORD_W-1:0] good_packets;
        logic              reliable_pending;
    } result_t;

endpackage

// ===== sv/sche_core.sv =====
// Channel state registers and the single-pass transmit/receive header logic.
module sche_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sche_pkg::in_item_t item,
    output sche_pkg::result_t  res
);
    import sche_pkg::*;

    logic [SEQ_W-1:0]  out_seq_reg, out_seq_next;
    logic [SEQ_W-1:0]  in_seq_reg, in_seq_next;
    logic [SEQ_W-1:0]  in_acked_reg, in_acked_next;
    logic [SEQ_W-1:0]  last_rel_seq_reg, last_rel_seq_next;
    logic              in_rel_acked_bit_reg, in_rel_acked_bit_next;
    logic              rel_bit_reg, rel_bit_next;
    logic              in_rel_bit_reg, in_rel_bit_next;
    logic              fatal_reg, fatal_next;
    logic [10:0]       held_len_reg, held_len_next;
    logic [WORD_W-1:0] drop_tally_reg, drop_tally_next;
    logic [WORD_W-1:0] good_tally_reg, good_tally_next;

    logic [SEQ_W-1:0]  seq_inc;
    logic [SEQ_W-1:0]  rx_seq;
    logic [SEQ_W-1:0]  rx_gap;
    logic              resend;
    logic              take;
    logic              sent;
    logic [LEN_W-1:0]  rel_part;
    logic [LEN_W-1:0]  size_hdr;

    always_comb
    begin
        out_seq_next          = out_seq_reg;
        in_seq_next           = in_seq_reg;
        in_acked_next         = in_acked_reg;
        last_rel_seq_next     = last_rel_seq_reg;
        in_rel_acked_bit_next = in_rel_acked_bit_reg;
        rel_bit_next          = rel_bit_reg;
        in_rel_bit_next       = in_rel_bit_reg;
        fatal_next            = fatal_reg;
        held_len_next         = held_len_reg;
        drop_tally_next       = drop_tally_reg;
        good_tally_next       = good_tally_reg;

        res          = '0;
        res.status   = ST_SENT;

        seq_inc  = out_seq_reg + SEQ_W'(1);
        rx_seq   = item.rx_sequence_word[SEQ_W-1:0];
        rx_gap   = rx_seq - in_seq_reg - SEQ_W'(1);
        resend   = (in_acked_reg > last_rel_seq_reg) &&
                   (in_rel_acked_bit_reg != rel_bit_reg);
        take     = (held_len_reg == '0) && (item.staged_bytes != '0);
        sent     = resend || take;
        rel_part = '0;
        size_hdr = HDR_BYTES;

        case (item.op)
            OP_TX:
            begin
                if (item.staged_overflow)
                begin
                    fatal_next = 1'b1;
                    res.status = ST_FATAL;
                end
                else
                begin
                    if (take)
                    begin
                        held_len_next = item.staged_bytes;
                        rel_bit_next  = ~rel_bit_reg;
                    end
                    out_seq_next = seq_inc;
                    if (sent)
                    begin
                        // reliable part is clipped to what is left after the header
                        rel_part = (held_len_next < REL_ROOM) ? held_len_next : REL_ROOM;
                        last_rel_seq_next = seq_inc;
                    end
                    size_hdr                 = HDR_BYTES + rel_part;
                    res.status               = ST_SENT;
                    res.tx_sequence_word     = {sent, out_seq_reg};
                    res.tx_ack_word          = {in_rel_bit_reg, in_seq_reg};
                    res.sent_reliable        = sent;
                    res.staged_taken         = take;
                    res.packet_bytes         = size_hdr;
                    if ((item.unreliable_bytes != '0) &&
                        ((PKT_CAP - size_hdr) >= item.unreliable_bytes))
                    begin
                        res.unreliable_included = 1'b1;
                        res.packet_bytes        = size_hdr + item.unreliable_bytes;
                    end
                end
            end
            OP_RX:
            begin
                if (!item.source_matches)
                    res.status = ST_WRONG_SRC;
                else if (rx_seq <= in_seq_reg)
                    res.status = ST_STALE;
                else
                begin
                    res.status          = ST_ACCEPTED;
                    res.packets_dropped = rx_gap;
                    if (rx_gap != '0)
                        drop_tally_next = drop_tally_reg + WORD_W'(1);
                    if (item.rx_ack_word[WORD_W-1] == rel_bit_reg)
                        held_len_next = '0;
                    in_seq_next           = rx_seq;
                    in_acked_next         = item.rx_ack_word[SEQ_W-1:0];
                    in_rel_acked_bit_next = item.rx_ack_word[WORD_W-1];
                    in_rel_bit_next       = in_rel_bit_reg ^ item.rx_sequence_word[WORD_W-1];
                    good_tally_next       = good_tally_reg + WORD_W'(1);
                end
            end
            default:
            begin
                res.status = ST_SENT;
            end
        endcase

        res.reliable_bytes   = held_len_next;
        res.reliable_pending = (held_len_next != '0);
        res.drop_events      = drop_tally_next;
        res.good_packets     = good_tally_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_seq_reg          <= '0;
            in_seq_reg           <= '0;
            in_acked_reg         <= '0;
            last_rel_seq_reg     <= '0;
            in_rel_acked_bit_reg <= 1'b0;
            rel_bit_reg          <= 1'b0;
            in_rel_bit_reg       <= 1'b0;
            fatal_reg            <= 1'b0;
            held_len_reg         <= '0;
            drop_tally_reg       <= '0;
            good_tally_reg       <= '0;
        end
        else if (fire)
        begin
            out_seq_reg          <= out_seq_next;
            in_seq_reg           <= in_seq_next;
            in_acked_reg         <= in_acked_next;
            last_rel_seq_reg     <= last_rel_seq_next;
            in_rel_acked_bit_reg <= in_rel_acked_bit_next;
            rel_bit_reg          <= rel_bit_next;
            in_rel_bit_reg       <= in_rel_bit_next;
            fatal_reg            <= fatal_next;
            held_len_reg         <= held_len_next;
            drop_tally_reg       <= drop_tally_next;
            good_tally_reg       <= good_tally_next;
        end
    end

endmodule

// ===== sv/sequenced_channel_header_engine_top.sv =====
// Each item is held in the input register, then in the result register.
// Throughput: one item per cycle while m_tready holds, set by the single-pass
// header logic between the input register and the result register.
// Reset (rst_n low, asynchronous): sequences, reliable bits, held length,
// tallies, fatal flag and the port tag clear to zero; both stages empty.
// Top level: stream handshake, input and result registers, config register.
module sequenced_channel_header_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel: port tag
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sche_pkg::TAG_W-1:0]      cfg_data,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // from bit 0: staged_bytes[10:0], staged_overflow, unreliable_bytes[10:0],
    // source_matches, rx_sequence_word[31:0], rx_ack_word[31:0]
    input  logic [sche_pkg::IN_TDATA_W-1:0] s_tdata,
    // op (0 transmit, 1 receive)
    input  logic                            s_tuser,
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // from bit 0: tx_sequence_word[31:0], tx_ack_word[31:0], sent_reliable,
    // staged_taken, reliable_bytes[10:0], unreliable_included,
    // packet_bytes[10:0], packets_dropped[30:0], drop_events[31:0],
    // good_packets[31:0], reliable_pending, zero fill to 192 bits
    output logic [sche_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]                      m_tuser
);
    import sche_pkg::*;

    // Input stage
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    in_item_t in_item;

    // Result stage
    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg;
    result_t  core_res;

    // Port tag is only held in this register; no result or output depends
    // on it.
    logic [TAG_W-1:0] port_tag_reg;

    logic advance;
    logic s_xfer;

    assign cfg_ready = 1'b1;

    // An item moves into the result register when that register is free
    // or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_item.op               = op_t'(s_tuser);
    assign in_item.staged_bytes     = s_tdata[10:0];
    assign in_item.staged_overflow  = s_tdata[11];
    assign in_item.unreliable_bytes = s_tdata[22:12];
    assign in_item.source_matches   = s_tdata[23];
    assign in_item.rx_sequence_word = s_tdata[55:24];
    assign in_item.rx_ack_word      = s_tdata[87:56];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            port_tag_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                port_tag_reg <= cfg_data;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_item_reg <= in_item;
        if (advance)
            out_res_reg <= core_res;
    end

    // State updates in the same cycle the item moves to the result stage.
    sche_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .res   (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {7'b0,
                       out_res_reg.reliable_pending,
                       out_res_reg.good_packets,
                       out_res_reg.drop_events,
                       out_res_reg.packets_dropped,
                       out_res_reg.packet_bytes,
                       out_res_reg.unreliable_included,
                       out_res_reg.reliable_bytes,
                       out_res_reg.staged_taken,
                       out_res_reg.sent_reliable,
                       out_res_reg.tx_ack_word,
                       out_res_reg.tx_sequence_word};

endmodule

// ===== sv/sche_checker.sv =====
// Port-level checks for the header engine, bound to the top level.
module sche_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sche_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [2:0]                       m_tuser
);
    import sche_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a sent packet always carries at least the header
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SENT) |-> (m_tdata[88:78] >= HDR_BYTES))
        else $error("packet shorter than header");

    // header only when nothing reliable or unreliable went in
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SENT) && !m_tdata[64] && !m_tdata[77]
        |-> (m_tdata[88:78] == HDR_BYTES))
        else $error("bare packet size wrong");

    // rejected headers build no words
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == ST_STALE) || (m_tuser == ST_WRONG_SRC))
        |-> (m_tdata[63:0] == '0) && (m_tdata[119:89] == '0))
        else $error("rejected item carries header words");

    // pending flag follows held length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[184] == (m_tdata[76:66] != '0)))
        else $error("pending flag mismatch");

endmodule

bind sequenced_channel_header_engine_top sche_checker u_sche_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
